### design/lgrs_pkg.sv
// Package for the Life generation row stepper.
// Holds widths, queue sizing, the job record and the B3/S23 row function.
// No dependencies; every other file imports it.
package lgrs_pkg;

   localparam int MAX_COLUMNS    = 64;
   localparam int ROW_BITS       = 64;
   localparam int WIDTH_BITS     = 7;
   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 7'd64;

   // Rule counts: birth on exactly three neighbors, survival on two or three.
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   // Job queue between the front and back parts.
   localparam int JOB_DEPTH      = 4;
   localparam int JOB_PTR_BITS   = $clog2(JOB_DEPTH);
   localparam int JOB_COUNT_BITS = $clog2(JOB_DEPTH + 1);

   // Number of rows held by the front part.
   typedef enum logic [1:0] {
      ROWS_NONE = 2'd0,
      ROWS_ONE  = 2'd1,
      ROWS_TWO  = 2'd2
   } rows_seen_type;

   // One unit of work for the back part. A job yields the result for the
   // middle row when has_first is set, and the result for the bottom row
   // (computed from middle and lower with a dead row below) when is_last is set.
   typedef struct packed {
      logic [ROW_BITS-1:0] upper;
      logic [ROW_BITS-1:0] middle;
      logic [ROW_BITS-1:0] lower;
      logic                has_first;
      logic                is_last;
   } job_type;

   // Mask of the columns in use; widths at or above the column count saturate.
   function automatic logic [ROW_BITS-1:0] column_mask(input logic [WIDTH_BITS-1:0] width);
      logic [ROW_BITS-1:0] mask;
      if (int'(width) >= MAX_COLUMNS) begin
         mask = {ROW_BITS{1'b1}};
      end else begin
         mask = ~({ROW_BITS{1'b1}} << width);
      end
      return mask;
   endfunction

   // Next state of one row from its two vertical neighbors.
   function automatic logic [ROW_BITS-1:0] life_next_row(
      input logic [ROW_BITS-1:0] above,
      input logic [ROW_BITS-1:0] here,
      input logic [ROW_BITS-1:0] below,
      input logic [ROW_BITS-1:0] mask
   );
      logic [ROW_BITS-1:0] a_l, a_r, h_l, h_r, b_l, b_r, a_m, h_m, b_m, res;
      logic [3:0]          count;
      a_m = above & mask;
      h_m = here & mask;
      b_m = below & mask;
      a_l = a_m << 1;
      a_r = a_m >> 1;
      h_l = h_m << 1;
      h_r = h_m >> 1;
      b_l = b_m << 1;
      b_r = b_m >> 1;
      res = '0;
      // Each column counts its eight neighbors independently.
      for (int i = 0; i < ROW_BITS; i++) begin
         count = {3'b0, a_l[i]} + {3'b0, a_m[i]} + {3'b0, a_r[i]}
               + {3'b0, h_l[i]} + {3'b0, h_r[i]}
               + {3'b0, b_l[i]} + {3'b0, b_m[i]} + {3'b0, b_r[i]};
         res[i] = (count == BIRTH_COUNT) || (h_m[i] && (count == SURVIVE_COUNT));
      end
      return res & mask;
   endfunction

endpackage

### design/lgrs_ifs.sv
// Channel interfaces for the Life generation row stepper.
// Row beats in, result beats out, and the width register write channel.
// Depends on lgrs_pkg.
interface lgrs_req_if;
   import lgrs_pkg::*;
   logic                valid;
   logic                ready;
   logic [ROW_BITS-1:0] row_cells;
   logic                final_row;
   modport source (output valid, output row_cells, output final_row, input ready);
   modport sink   (input valid, input row_cells, input final_row, output ready);
endinterface

interface lgrs_rsp_if;
   import lgrs_pkg::*;
   logic                valid;
   logic                ready;
   logic [ROW_BITS-1:0] next_cells;
   logic                frame_done;
   modport source (output valid, output next_cells, output frame_done, input ready);
   modport sink   (input valid, input next_cells, input frame_done, output ready);
endinterface

interface lgrs_csr_if;
   import lgrs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [WIDTH_BITS-1:0] grid_width;
   modport source (output valid, output grid_width, input ready);
   modport sink   (input valid, input grid_width, output ready);
endinterface

### design/lgrs_front.sv
// Front part: accepts row beats, keeps the two previous rows and forms jobs.
// Depends on lgrs_pkg and lgrs_req_if.
module lgrs_front (
   input  logic                          clock,
   input  logic                          reset,
   lgrs_req_if.sink                      req_if,
   input  logic [lgrs_pkg::ROW_BITS-1:0] col_mask,
   output logic                          job_valid,
   input  logic                          job_ready,
   output lgrs_pkg::job_type             job
);
   import lgrs_pkg::*;

   logic [ROW_BITS-1:0] upper_ff, upper_in;
   logic [ROW_BITS-1:0] middle_ff, middle_in;
   rows_seen_type       rows_seen_ff, rows_seen_in;
   logic [ROW_BITS-1:0] row_m;
   logic                held;
   logic                accept;

   // A beat is taken only when the queue has room for its job.
   assign req_if.ready = job_ready;
   assign accept       = req_if.valid && job_ready;
   assign row_m        = req_if.row_cells & col_mask;
   assign held         = (rows_seen_ff != ROWS_NONE);

   // Job for this beat; held rows are masked with the width now in force.
   always_comb begin
      job.upper     = upper_ff & col_mask;
      job.middle    = middle_ff & col_mask;
      job.lower     = row_m;
      job.has_first = held;
      job.is_last   = req_if.final_row;
      job_valid     = req_if.valid && (held || req_if.final_row);
   end

   // Row history update.
   always_comb begin
      upper_in     = upper_ff;
      middle_in    = middle_ff;
      rows_seen_in = rows_seen_ff;
      if (accept) begin
         if (req_if.final_row) begin
            upper_in     = '0;
            middle_in    = '0;
            rows_seen_in = ROWS_NONE;
         end else begin
            upper_in     = held ? middle_ff : '0;
            middle_in    = row_m;
            rows_seen_in = held ? ROWS_TWO : ROWS_ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff     <= '0;
         middle_ff    <= '0;
         rows_seen_ff <= ROWS_NONE;
      end else begin
         upper_ff     <= upper_in;
         middle_ff    <= middle_in;
         rows_seen_ff <= rows_seen_in;
      end
   end

endmodule

### design/lgrs_job_fifo.sv
// Short job queue between the front and back parts.
// Depends on lgrs_pkg for the job record and depth.
module lgrs_job_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  lgrs_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output lgrs_pkg::job_type pop_job
);
   import lgrs_pkg::*;

   job_type                   entries_ff [JOB_DEPTH];
   logic [JOB_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [JOB_COUNT_BITS-1:0] count_ff, count_in;
   logic                      do_push, do_pop;

   assign push_ready = (count_ff != JOB_COUNT_BITS'(JOB_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### design/lgrs_back.sv
// Back part: applies the B3/S23 rule to queued jobs and drives result beats.
// Depends on lgrs_pkg and lgrs_rsp_if.
module lgrs_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lgrs_pkg::ROW_BITS-1:0] col_mask,
   input  logic                          job_valid,
   output logic                          job_ready,
   input  lgrs_pkg::job_type             job,
   lgrs_rsp_if.source                    rsp_if
);
   import lgrs_pkg::*;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ROW_BITS-1:0] cells_ff, cells_in;
   logic                done_ff, done_in;
   logic                phase_ff, phase_in;
   logic                first_step, load, take;
   logic [ROW_BITS-1:0] above, here, below;

   // A job with a middle-row result gives that first, then the bottom row if is_last is set.
   assign first_step = job.has_first && !phase_ff;
   assign load       = !rsp_valid_ff || rsp_if.ready;
   assign take       = job_valid && load;
   assign job_ready  = take && !(first_step && job.is_last);

   // Pick the row triple for this step and evaluate the rule.
   always_comb begin
      if (first_step) begin
         above = job.upper;
         here  = job.middle;
         below = job.lower;
      end else begin
         above = job.middle;
         here  = job.lower;
         below = '0;
      end
      cells_in = life_next_row(above, here, below, col_mask);
      done_in  = !first_step;
   end

   // Output register and phase control.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      phase_in     = phase_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         phase_in     = first_step && job.is_last;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cells_ff <= cells_in;
         done_ff  <= done_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.next_cells = cells_ff;
   assign rsp_if.frame_done = done_ff;

endmodule

### design/life_generation_row_stepper.sv
// One Life (B3/S23) generation, row by row. A row beat is accepted every cycle
// while the job queue has room; its job is queued, then the result is registered.
// The result stage issues one beat per cycle while the receiver is ready, so a
// bottom row that closes a grid of two or more rows uses it for two beats.
// Reset (synchronous): held rows and queue cleared, grid_width set to 64.
// Depends on lgrs_pkg, lgrs_ifs, lgrs_front, lgrs_job_fifo and lgrs_back.
module life_generation_row_stepper (
   input  logic        clock,
   input  logic        reset,
   lgrs_req_if.sink    req_if,
   lgrs_rsp_if.source  rsp_if,
   lgrs_csr_if.sink    csr_if
);
   import lgrs_pkg::*;

   logic [WIDTH_BITS-1:0] width_ff, width_in;
   logic [ROW_BITS-1:0]   col_mask;
   logic                  fj_valid, fj_ready, bj_valid, bj_ready;
   job_type               f_job, b_job;

   // Width register; writes are always taken.
   assign csr_if.ready = 1'b1;
   assign width_in     = csr_if.valid ? csr_if.grid_width : width_ff;
   assign col_mask     = column_mask(width_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else begin
         width_ff <= width_in;
      end
   end

   lgrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .col_mask  (col_mask),
      .job_valid (fj_valid),
      .job_ready (fj_ready),
      .job       (f_job)
   );

   lgrs_job_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fj_valid),
      .push_ready (fj_ready),
      .push_job   (f_job),
      .pop_valid  (bj_valid),
      .pop_ready  (bj_ready),
      .pop_job    (b_job)
   );

   lgrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .col_mask  (col_mask),
      .job_valid (bj_valid),
      .job_ready (bj_ready),
      .job       (b_job),
      .rsp_if    (rsp_if)
   );

   // Results never carry live cells in unused columns.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> ((rsp_if.next_cells & ~col_mask) == '0))
      else $error("result has live cells beyond grid width");

   // Every queued job produces at least one result.
   assert property (@(posedge clock) disable iff (reset)
      bj_valid |-> (b_job.has_first || b_job.is_last))
      else $error("queued job with no result");

   // A stalled queue holds back row beats.
   assert property (@(posedge clock) disable iff (reset)
      !fj_ready |-> !req_if.ready)
      else $error("row beat accepted while job queue full");

endmodule

### tb/sv/testbench.sv
// Testbench for life_generation_row_stepper: streams Life grids row by row and
// checks every next-generation beat against a predictor held in a scoreboard class.
// Depends on lgrs_pkg, lgrs_ifs and the design files.
module testbench;
   import lgrs_pkg::*;

   localparam int ROW_TARGET    = 550;
   localparam int SETTLE_CYCLES = 8;
   localparam int RUN_LIMIT     = 2_400_000;

   // Receiver stall patterns.
   typedef enum int {
      RX_OPEN     = 0,
      RX_RANDOM   = 1,
      RX_PERIODIC = 2
   } rx_mode_type;

   typedef struct {
      logic [ROW_BITS-1:0] cells;
      logic                done;
   } row_result_type;

   // Predicts next-generation rows from accepted row beats and checks result beats.
   class generation_scoreboard;
      logic [WIDTH_BITS-1:0] grid_width;
      logic [ROW_BITS-1:0]   upper_row;
      logic [ROW_BITS-1:0]   middle_row;
      rows_seen_type         held_rows;
      row_result_type        expected_rows[$];
      int                    mismatches;
      int                    results_checked;

      function new();
         grid_width      = WIDTH_RESET;
         upper_row       = '0;
         middle_row      = '0;
         held_rows       = ROWS_NONE;
         mismatches      = 0;
         results_checked = 0;
      endfunction

      task report(string what);
         mismatches++;
         $display("MISMATCH at %0t: %s", $time, what);
      endtask

      function int pending();
         return expected_rows.size();
      endfunction

      function void set_width(logic [WIDTH_BITS-1:0] w);
         grid_width = w;
      endfunction

      // Columns in use; widths past the column count saturate.
      function logic [ROW_BITS-1:0] width_mask();
         if (int'(grid_width) >= MAX_COLUMNS) begin
            return {ROW_BITS{1'b1}};
         end
         return (64'b1 << grid_width) - 64'b1;
      endfunction

      // B3/S23 on one row, with dead cells past both ends of the row.
      function logic [ROW_BITS-1:0] evolve_row(logic [ROW_BITS-1:0] above,
                                               logic [ROW_BITS-1:0] here,
                                               logic [ROW_BITS-1:0] below,
                                               logic [ROW_BITS-1:0] mask);
         logic [ROW_BITS-1:0] band[3];
         logic [ROW_BITS-1:0] next;
         int                  live;
         band[0] = above & mask;
         band[1] = here & mask;
         band[2] = below & mask;
         next    = '0;
         for (int c = 0; c < ROW_BITS; c++) begin
            live = 0;
            for (int k = 0; k < 3; k++) begin
               for (int d = -1; d <= 1; d++) begin
                  if (!(k == 1 && d == 0) && c + d >= 0 && c + d < ROW_BITS) begin
                     live += band[k][c+d];
                  end
               end
            end
            next[c] = (live == 3) || (band[1][c] && live == 2);
         end
         return next & mask;
      endfunction

      // An accepted row closes the row above it, and a bottom row closes itself too.
      function void note_row(logic [ROW_BITS-1:0] row, logic last);
         logic [ROW_BITS-1:0] mask;
         logic [ROW_BITS-1:0] cur;
         logic                held;
         row_result_type      res;
         mask = width_mask();
         cur  = row & mask;
         held = (held_rows != ROWS_NONE);
         if (held) begin
            res.cells = evolve_row(upper_row, middle_row, cur, mask);
            res.done  = 1'b0;
            expected_rows.push_back(res);
         end
         if (last) begin
            res.cells = evolve_row(held ? middle_row : '0, cur, '0, mask);
            res.done  = 1'b1;
            expected_rows.push_back(res);
            upper_row  = '0;
            middle_row = '0;
            held_rows  = ROWS_NONE;
         end else begin
            upper_row  = held ? middle_row : '0;
            middle_row = cur;
            held_rows  = held ? ROWS_TWO : ROWS_ONE;
         end
      endfunction

      task check_row(logic [ROW_BITS-1:0] cells, logic done);
         row_result_type want;
         results_checked++;
         if (expected_rows.size() == 0) begin
            report($sformatf("result beat with nothing expected: cells %h done %b",
                             cells, done));
         end else begin
            want = expected_rows.pop_front();
            if (cells !== want.cells) begin
               report($sformatf("next_cells %h, expected %h", cells, want.cells));
            end
            if (done !== want.done) begin
               report($sformatf("frame_done %b, expected %b", done, want.done));
            end
         end
      endtask
   endclass

   logic clock;
   logic reset;

   lgrs_req_if req_ch();
   lgrs_rsp_if rsp_ch();
   lgrs_csr_if csr_ch();

   generation_scoreboard life_check = new();

   int rows_sent;
   int grids_sent;
   int widths_written;
   int burst_left;

   life_generation_row_stepper u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // Clock with a period of 12.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Result monitor samples on the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         life_check.check_row(rsp_ch.next_cells, rsp_ch.frame_done);
      end
   end

   // Receiver: switches between open, random and periodic stalls in stretches.
   initial begin
      rx_mode_type mode;
      int          span;
      int          tick;
      rsp_ch.ready = 1'b0;
      tick = 0;
      forever begin
         mode = rx_mode_type'($urandom_range(0, 2));
         span = $urandom_range(16, 80);
         repeat (span) begin
            @(negedge clock);
            tick++;
            case (mode)
               RX_OPEN: begin
                  rsp_ch.ready <= 1'b1;
               end
               RX_RANDOM: begin
                  rsp_ch.ready <= 1'($urandom_range(0, 1));
               end
               default: begin
                  rsp_ch.ready <= (tick % 5) < 2;
               end
            endcase
         end
      end
   end

   // Sends one row beat; the sender works in bursts with random gaps between.
   task send_row(input logic [ROW_BITS-1:0] cells, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 5);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                  : $urandom_range(1, 8);
      end
      req_ch.valid     <= 1'b1;
      req_ch.row_cells <= cells;
      req_ch.final_row <= last;
      do @(posedge clock); while (!req_ch.ready);
      life_check.note_row(cells, last);
      rows_sent++;
      if (last) begin
         grids_sent++;
      end
      burst_left--;
      @(negedge clock);
   endtask

   // Waits until every expected beat is out, then lets the pipeline drain.
   task settle();
      req_ch.valid <= 1'b0;
      while (life_check.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register writes happen only with the block idle.
   task write_width(input logic [WIDTH_BITS-1:0] w);
      settle();
      csr_ch.valid      <= 1'b1;
      csr_ch.grid_width <= w;
      do @(posedge clock); while (!csr_ch.ready);
      life_check.set_width(w);
      widths_written++;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Random row content: dense, sparse, uniform or a short pattern anywhere.
   function automatic logic [ROW_BITS-1:0] random_row();
      logic [ROW_BITS-1:0] a;
      logic [ROW_BITS-1:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0:       return a & b & {$urandom, $urandom};
         1:       return a | b;
         2:       return 64'h7 << $urandom_range(0, 63);
         3:       return ($urandom_range(0, 1) == 1) ? '1 : '0;
         default: return a;
      endcase
   endfunction

   function automatic logic [WIDTH_BITS-1:0] pick_width();
      case ($urandom_range(0, 9))
         0:       return 7'd0;
         1:       return 7'd127;
         2:       return 7'($urandom_range(65, 126));
         3:       return 7'd64;
         4:       return 7'($urandom_range(1, 3));
         default: return 7'($urandom_range(1, 63));
      endcase
   endfunction

   // Main stimulus.
   initial begin
      int grids;
      int height;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.row_cells  = '0;
      req_ch.final_row  = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.grid_width = '0;
      rows_sent         = 0;
      grids_sent        = 0;
      widths_written    = 0;
      burst_left        = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Single-row grids at the reset width, full and empty.
      send_row('1, 1'b1);
      send_row('0, 1'b1);
      // A full row between two empty ones.
      send_row('0, 1'b0);
      send_row('1, 1'b0);
      send_row('0, 1'b1);
      // Cells on both edge columns.
      send_row(64'h8000_0000_0000_0001, 1'b0);
      send_row(64'h8000_0000_0000_0001, 1'b0);
      send_row(64'h8000_0000_0000_0001, 1'b1);
      // A glider against the high edge.
      send_row(64'h2 << 61, 1'b0);
      send_row(64'h4 << 61, 1'b0);
      send_row(64'h7 << 61, 1'b1);

      // Width zero leaves every column dead.
      write_width(7'd0);
      send_row('1, 1'b0);
      send_row('1, 1'b1);

      // A width past the column count behaves as the full row.
      write_width(7'd127);
      send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      send_row(64'h5555_5555_5555_5555, 1'b0);
      send_row('1, 1'b1);

      // One column only: bits above it are ignored.
      write_width(7'd1);
      send_row('1, 1'b0);
      send_row('1, 1'b0);
      send_row('1, 1'b1);

      // Width narrowed while rows are held, so held rows are masked again.
      write_width(7'd5);
      send_row('1, 1'b0);
      send_row('1, 1'b0);
      write_width(7'd3);
      send_row('1, 1'b1);

      // Random phases: a width, then grids of random height; some phases leave a
      // grid open so the next width takes effect in the middle of it.
      while (rows_sent < ROW_TARGET) begin
         write_width(pick_width());
         grids = $urandom_range(2, 6);
         repeat (grids) begin
            height = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 8);
            for (int r = 0; r < height; r++) begin
               send_row(random_row(), r == height - 1);
            end
         end
         if ($urandom_range(0, 3) == 0) begin
            height = $urandom_range(1, 2);
            repeat (height) send_row(random_row(), 1'b0);
         end
      end
      // Close any grid still open.
      send_row(random_row(), 1'b1);
      settle();

      if (life_check.pending() != 0) begin
         life_check.report($sformatf("%0d expected beats never arrived",
                                     life_check.pending()));
      end
      $display("Run covered %0d row beats in %0d grids under %0d width writes,",
               rows_sent, grids_sent, widths_written);
      $display("with %0d result beats checked and %0d mismatches.",
               life_check.results_checked, life_check.mismatches);
      if (life_check.mismatches == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #RUN_LIMIT;
      $display("Run stopped by the time limit with %0d row beats sent.", rows_sent);
      $display("testbench failed");
      $finish;
   end

endmodule

### sim.f
design/lgrs_pkg.sv
design/lgrs_ifs.sv
design/lgrs_front.sv
design/lgrs_job_fifo.sv
design/lgrs_back.sv
design/life_generation_row_stepper.sv
tb/sv/testbench.sv
